// ===== hdl/xzr_pkg.sv =====
// Shared types, constants, coefficient table and microprogram of the zigzag resampler.
`default_nettype none

package xzr_pkg;

  localparam int HIST_DEPTH_DEF = 32;
  localparam int TAPS           = 29;
  localparam int PHASES         = 7;
  localparam int TAP_W          = $clog2(TAPS);
  localparam int PHASE_W        = $clog2(PHASES + 1);
  localparam int FUB_W          = 3;
  localparam int ACC_W          = 20;
  localparam int STEP_W         = 4;

  localparam logic [FUB_W-1:0] BURST_FRAMES = 3'd6;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 20'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -20'sd32768;

  // Register selects on paddr bit 2.
  localparam logic REG_HALF_RATE = 1'b0;
  localparam logic REG_STEREO    = 1'b1;

  // Microprogram step addresses.
  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_WRITE = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CHECK = 4'd2;
  localparam logic [STEP_W-1:0] STEP_AGAIN = 4'd3;
  localparam logic [STEP_W-1:0] STEP_BINIT = 4'd4;
  localparam logic [STEP_W-1:0] STEP_PINIT = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MAC   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DRN1  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DRN2  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_NEXT  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_DONE  = 4'd11;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BURST,
    COND_NO_REPEAT,
    COND_TAP_MORE,
    COND_OUT_BUSY,
    COND_PHASE_MORE
  } cond_e;

  typedef struct packed {
    logic              accept;
    logic              wr_frame;
    logic              set_second;
    logic              clr_phase;
    logic              clr_acc;
    logic              issue;
    logic              emit;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic burst;
    logic no_repeat;
    logic tap_more;
    logic out_busy;
    logic phase_more;
  } stat_t;

  localparam logic signed [15:0] COEF_TABLE [PHASES][TAPS] = '{
    '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, -16'sh0002, 16'sh000A,
      -16'sh0022, 16'sh0041, -16'sh0054, 16'sh0034, 16'sh0009, -16'sh010A, 16'sh0400,
      -16'sh0A78, 16'sh234C, 16'sh6794, -16'sh1780, 16'sh0BCD, -16'sh0623, 16'sh0350,
      -16'sh016D, 16'sh006B, 16'sh000A, -16'sh0010, 16'sh0011, -16'sh0008, 16'sh0003,
      -16'sh0001},
    '{16'sh0000, 16'sh0000, 16'sh0000, -16'sh0002, 16'sh0000, 16'sh0003, -16'sh0013,
      16'sh003C, -16'sh004B, 16'sh00A2, -16'sh00E3, 16'sh0132, -16'sh0043, -16'sh0267,
      16'sh0C9D, 16'sh74BB, -16'sh11B4, 16'sh09B8, -16'sh05BF, 16'sh0372, -16'sh01A8,
      16'sh00A6, -16'sh001B, 16'sh0005, 16'sh0006, -16'sh0008, 16'sh0003, -16'sh0001,
      16'sh0000},
    '{16'sh0000, 16'sh0000, -16'sh0001, 16'sh0003, -16'sh0002, -16'sh0005, 16'sh001F,
      -16'sh004A, 16'sh00B3, -16'sh0192, 16'sh02B1, -16'sh039E, 16'sh04F8, -16'sh05A6,
      16'sh7939, -16'sh05A6, 16'sh04F8, -16'sh039E, 16'sh02B1, -16'sh0192, 16'sh00B3,
      -16'sh004A, 16'sh001F, -16'sh0005, -16'sh0002, 16'sh0003, -16'sh0001, 16'sh0000,
      16'sh0000},
    '{16'sh0000, -16'sh0001, 16'sh0003, -16'sh0008, 16'sh0006, 16'sh0005, -16'sh001B,
      16'sh00A6, -16'sh01A8, 16'sh0372, -16'sh05BF, 16'sh09B8, -16'sh11B4, 16'sh74BB,
      16'sh0C9D, -16'sh0267, -16'sh0043, 16'sh0132, -16'sh00E3, 16'sh00A2, -16'sh004B,
      16'sh003C, -16'sh0013, 16'sh0003, 16'sh0000, -16'sh0002, 16'sh0000, 16'sh0000,
      16'sh0000},
    '{-16'sh0001, 16'sh0003, -16'sh0008, 16'sh0011, -16'sh0010, 16'sh000A, 16'sh006B,
      -16'sh016D, 16'sh0350, -16'sh0623, 16'sh0BCD, -16'sh1780, 16'sh6794, 16'sh234C,
      -16'sh0A78, 16'sh0400, -16'sh010A, 16'sh0009, 16'sh0034, -16'sh0054, 16'sh0041,
      -16'sh0022, 16'sh000A, -16'sh0002, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
      16'sh0000},
    '{16'sh0002, -16'sh0008, 16'sh0010, -16'sh0023, 16'sh002B, 16'sh001A, -16'sh00EB,
      16'sh027B, -16'sh0548, 16'sh0AFA, -16'sh16FA, 16'sh53E0, 16'sh3C07, -16'sh1249,
      16'sh080E, -16'sh0347, 16'sh015B, -16'sh0044, -16'sh0017, 16'sh0046, -16'sh0023,
      16'sh0011, -16'sh0005, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
      16'sh0000},
    '{-16'sh0005, 16'sh0011, -16'sh0023, 16'sh0046, -16'sh0017, -16'sh0044, 16'sh015B,
      -16'sh0347, 16'sh080E, -16'sh1249, 16'sh3C07, 16'sh53E0, -16'sh16FA, 16'sh0AFA,
      -16'sh0548, 16'sh027B, -16'sh00EB, 16'sh001A, 16'sh002B, -16'sh0023, 16'sh0010,
      -16'sh0008, 16'sh0002, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
      16'sh0000}
  };

  function automatic logic signed [15:0] coef_f(input logic [PHASE_W-1:0] phase,
                                                input logic [TAP_W-1:0] tap);
    logic signed [15:0] c;
    c = 16'sh0000;
    if ((phase < PHASE_W'(PHASES)) && (tap < TAP_W'(TAPS))) begin
      c = COEF_TABLE[phase[PHASE_W-1:0]][tap];
    end
    return c;
  endfunction

  // Control store: one word per step, jump to target when the condition holds.
  function automatic uword_t ucode_f(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    w.cond   = COND_NEVER;
    w.target = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = STEP_IDLE;
      end
      STEP_WRITE: begin
        w.wr_frame = 1'b1;
        w.cond     = COND_BURST;
        w.target   = STEP_BINIT;
      end
      STEP_CHECK: begin
        w.cond   = COND_NO_REPEAT;
        w.target = STEP_IDLE;
      end
      STEP_AGAIN: begin
        w.set_second = 1'b1;
        w.cond       = COND_ALWAYS;
        w.target     = STEP_WRITE;
      end
      STEP_BINIT: begin
        w.clr_phase = 1'b1;
      end
      STEP_PINIT: begin
        w.clr_acc = 1'b1;
      end
      STEP_MAC: begin
        w.issue  = 1'b1;
        w.cond   = COND_TAP_MORE;
        w.target = STEP_MAC;
      end
      STEP_DRN1, STEP_DRN2: begin
        w.cond = COND_NEVER;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      STEP_NEXT: begin
        w.cond   = COND_PHASE_MORE;
        w.target = STEP_PINIT;
      end
      STEP_DONE: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_CHECK;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/xa_zigzag_resampler_top.sv =====
// Top level of the zigzag resampler: APB register file, sequencer and datapath.
`default_nettype none

// Converts 37.8 kHz (or 18.9 kHz with half_rate set) audio frames to 44.1 kHz.
// Input channel: a frame (left_sample_i, right_sample_i) is taken when
// in_valid_i is high and in_stall_o is low. Each frame is written once, or
// twice at half rate, into the history ring; every sixth write starts a run
// of seven stereo results on the output channel, the last one flagged by
// last_of_run_o. A result transaction completes when out_valid_o is high and
// out_stall_i is low.
// Each result of a run is computed on the two MAC lanes, one per channel,
// reading one history entry per cycle over the 29 taps from the single read
// port of the history RAM, then draining the read/multiply/add pipeline, with
// further steps for setup, output and stepping.
// While the receiver stalls, the finished result holds in the output register
// and the sequencer waits before loading the next one; the input stays
// stalled until the run ends. Reset clears the history (through per-entry
// valid bits, no clearing pass) and the write pointer, reloads the run counter
// and sets half_rate to 0 and stereo to 1. Registers are to be written by the
// user only while idle; the block itself does not enforce this.
module xa_zigzag_resampler_top import xzr_pkg::*; #(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] left_sample_i,
  input  wire logic signed [15:0] right_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      left_out_o,
  output logic signed [15:0]      right_out_o,
  output logic                    last_of_run_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic   half_rate_q, stereo_q;
  logic   cfg_wr;
  uword_t ctrl;
  stat_t  stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_rate_q <= 1'b0;
      stereo_q    <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HALF_RATE: half_rate_q <= pwdata[0];
        REG_STEREO:    stereo_q    <= pwdata[0];
        default:       half_rate_q <= half_rate_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HALF_RATE: prdata = {31'h0, half_rate_q};
      REG_STEREO:    prdata = {31'h0, stereo_q};
      default:       prdata = 32'h0;
    endcase
  end

  xzr_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  xzr_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .half_rate_i    (half_rate_q),
    .stereo_i       (stereo_q),
    .in_valid_i     (in_valid_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .last_of_run_o  (last_of_run_o)
  );

  assign in_stall_o = !ctrl.accept;

endmodule

`default_nettype wire

// ===== hdl/xzr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module xzr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/xzr_useq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module xzr_useq import xzr_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire stat_t  stat_i,
  output uword_t      ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  uword_t            uw;
  logic              take;

  always_comb begin
    uw = ucode_f(step_q);
    case (uw.cond)
      COND_NEVER:      take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_NO_INPUT:   take = !stat_i.in_valid;
      COND_BURST:      take = stat_i.burst;
      COND_NO_REPEAT:  take = stat_i.no_repeat;
      COND_TAP_MORE:   take = stat_i.tap_more;
      COND_OUT_BUSY:   take = stat_i.out_busy;
      COND_PHASE_MORE: take = stat_i.phase_more;
      default:         take = 1'b0;
    endcase
    step_d = take ? uw.target : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = uw;

  a_accept_to_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.accept && stat_i.in_valid) |=> (step_q == STEP_WRITE))
    else $error("accepted transaction not followed by history write");

  a_burst_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_WRITE && stat_i.burst) |=> (step_q == STEP_BINIT))
    else $error("burst write did not start the filter program");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_DONE)
    else $error("step counter left the program");

endmodule

`default_nettype wire

// ===== hdl/xzr_datapath.sv =====
// Datapath: frame latch, history RAM with valid bits, two MAC lanes, saturation, output register.
`default_nettype none

module xzr_datapath import xzr_pkg::*; #(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire uword_t             ctrl_i,
  output stat_t                   stat_o,
  input  wire logic               half_rate_i,
  input  wire logic               stereo_i,
  input  wire logic               in_valid_i,
  input  wire logic signed [15:0] left_sample_i,
  input  wire logic signed [15:0] right_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      left_out_o,
  output logic signed [15:0]      right_out_o,
  output logic                    last_of_run_o
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

  logic                     in_fire, emit_fire, out_busy;
  logic [31:0]              frame_q;
  logic [AW-1:0]            wp_q;
  logic [FUB_W-1:0]         fub_q;
  logic                     second_q;
  logic [PHASE_W-1:0]       phase_q;
  logic [TAP_W-1:0]         tap_q, tap1_q;
  logic [HISTORY_DEPTH-1:0] hvld_q;
  logic                     rd_v_q, mul_v_q, hit_q;
  logic [AW:0]              rd_sum;
  logic [AW-1:0]            rd_addr;
  logic [31:0]              ram_rdata, smp;
  logic signed [15:0]       coef;
  logic signed [31:0]       prod_l_d, prod_r_d, prod_l_q, prod_r_q;
  logic signed [ACC_W-1:0]  acc_l_q, acc_r_q, acc_l_d, acc_r_d;
  logic                     out_valid_q, last_q;
  logic signed [15:0]       left_q, right_q, sat_l, sat_r;

  assign in_fire   = ctrl_i.accept && in_valid_i;
  assign out_busy  = out_valid_q && out_stall_i;
  assign emit_fire = ctrl_i.emit && !out_busy;

  always_comb begin
    stat_o.in_valid   = in_valid_i;
    stat_o.burst      = (fub_q <= FUB_W'(1));
    stat_o.no_repeat  = !half_rate_i || second_q;
    stat_o.tap_more   = (tap_q != TAP_W'(TAPS - 1));
    stat_o.out_busy   = out_busy;
    stat_o.phase_more = (phase_q != PHASE_W'(PHASES));
  end

  // Tap i reads the frame written i+1 writes ago, wrapping around the ring.
  always_comb begin
    rd_sum  = (AW + 1)'(wp_q) - (AW + 1)'(tap_q) - (AW + 1)'(1);
    rd_addr = rd_sum[AW] ? AW'(rd_sum + DEPTH_W) : rd_sum[AW-1:0];
  end

  xzr_ram #(
    .WIDTH (32),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_frame),
    .waddr_i (wp_q),
    .wdata_i (frame_q),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Entries never written read as zero.
  always_comb begin
    smp      = hit_q ? ram_rdata : 32'h0;
    coef     = coef_f(phase_q, tap1_q);
    prod_l_d = $signed(smp[15:0]) * coef;
    prod_r_d = $signed(smp[31:16]) * coef;
    acc_l_d  = acc_l_q + {{(ACC_W - 17){prod_l_q[31]}}, prod_l_q[31:15]};
    acc_r_d  = acc_r_q + {{(ACC_W - 17){prod_r_q[31]}}, prod_r_q[31:15]};
  end

  always_comb begin
    if (acc_l_q > SAT_MAX) begin
      sat_l = 16'sh7FFF;
    end else if (acc_l_q < SAT_MIN) begin
      sat_l = 16'sh8000;
    end else begin
      sat_l = acc_l_q[15:0];
    end
    if (acc_r_q > SAT_MAX) begin
      sat_r = 16'sh7FFF;
    end else if (acc_r_q < SAT_MIN) begin
      sat_r = 16'sh8000;
    end else begin
      sat_r = acc_r_q[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fub_q       <= BURST_FRAMES;
      second_q    <= 1'b0;
      phase_q     <= '0;
      tap_q       <= '0;
      hvld_q      <= '0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_frame) begin
        hvld_q[wp_q] <= 1'b1;
        wp_q         <= (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
        fub_q        <= (fub_q <= FUB_W'(1)) ? BURST_FRAMES : fub_q - FUB_W'(1);
      end
      if (in_fire) begin
        second_q <= 1'b0;
      end else if (ctrl_i.set_second) begin
        second_q <= 1'b1;
      end
      if (ctrl_i.clr_phase) begin
        phase_q <= '0;
      end else if (emit_fire) begin
        phase_q <= phase_q + PHASE_W'(1);
      end
      if (ctrl_i.clr_acc) begin
        tap_q <= '0;
      end else if (ctrl_i.issue) begin
        tap_q <= tap_q + TAP_W'(1);
      end
      rd_v_q      <= ctrl_i.issue;
      mul_v_q     <= rd_v_q;
      out_valid_q <= emit_fire || out_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frame_q <= {stereo_i ? right_sample_i : left_sample_i, left_sample_i};
    end
    hit_q    <= hvld_q[rd_addr];
    tap1_q   <= tap_q;
    prod_l_q <= prod_l_d;
    prod_r_q <= prod_r_d;
    if (ctrl_i.clr_acc) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (mul_v_q) begin
      acc_l_q <= acc_l_d;
      acc_r_q <= acc_r_d;
    end
    if (emit_fire) begin
      left_q  <= sat_l;
      right_q <= sat_r;
      last_q  <= (phase_q == PHASE_W'(PHASES - 1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_out_o    = left_q;
  assign right_out_o   = right_q;
  assign last_of_run_o = last_q;

  a_mac_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> (!rd_v_q && !mul_v_q))
    else $error("result taken before the MAC pipeline drained");

  a_fub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fub_q >= FUB_W'(1)) && (fub_q <= BURST_FRAMES))
    else $error("burst frame counter out of range");

  a_gap_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q && !out_stall_i) |=> !out_valid_q)
    else $error("result followed the last of a run back to back");

endmodule

`default_nettype wire

// ===== verif/xa_zigzag_resampler_top_test.sv =====
// Self-checking testbench for the zigzag resampler: a directed table of frames, then random frames.
module xa_zigzag_resampler_top_test;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int RANDOM_FRAMES = 258;
  localparam int IDLE_PCT      = 38;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRILL_ROWS    = 22;
  localparam int FILTER_TAPS   = 29;
  localparam int FILTER_PHASES = 7;
  localparam int RUN_FRAMES    = 6;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } audio_out_t;

  typedef struct packed {
    logic        cfg;
    logic        half;
    logic        ster;
    logic [15:0] left;
    logic [15:0] right;
    logic        typed;
    logic [15:0] left_exp;
    logic [15:0] right_exp;
  } drill_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] left_sample_i = '0;
  logic signed [15:0] right_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] left_out_o;
  logic signed [15:0] right_out_o;
  logic               last_of_run_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Resampler state as predicted by the testbench.
  logic [31:0] hist_mem [32];
  logic [4:0]  hist_wp;
  logic [2:0]  writes_left;
  logic        half_rate_m;
  logic        stereo_m;

  audio_out_t pending_out [$];

  int  errors = 0;
  int  frames_sent = 0;
  int  results_seen = 0;
  int  runs_predicted = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;

  int zigzag [FILTER_PHASES][FILTER_TAPS] = '{
    '{0, 0, 0, 0, 0, -'h0002, 'h000A, -'h0022, 'h0041, -'h0054,
      'h0034, 'h0009, -'h010A, 'h0400, -'h0A78, 'h234C, 'h6794, -'h1780, 'h0BCD, -'h0623,
      'h0350, -'h016D, 'h006B, 'h000A, -'h0010, 'h0011, -'h0008, 'h0003, -'h0001},
    '{0, 0, 0, -'h0002, 0, 'h0003, -'h0013, 'h003C, -'h004B, 'h00A2,
      -'h00E3, 'h0132, -'h0043, -'h0267, 'h0C9D, 'h74BB, -'h11B4, 'h09B8, -'h05BF, 'h0372,
      -'h01A8, 'h00A6, -'h001B, 'h0005, 'h0006, -'h0008, 'h0003, -'h0001, 0},
    '{0, 0, -'h0001, 'h0003, -'h0002, -'h0005, 'h001F, -'h004A, 'h00B3, -'h0192,
      'h02B1, -'h039E, 'h04F8, -'h05A6, 'h7939, -'h05A6, 'h04F8, -'h039E, 'h02B1, -'h0192,
      'h00B3, -'h004A, 'h001F, -'h0005, -'h0002, 'h0003, -'h0001, 0, 0},
    '{0, -'h0001, 'h0003, -'h0008, 'h0006, 'h0005, -'h001B, 'h00A6, -'h01A8, 'h0372,
      -'h05BF, 'h09B8, -'h11B4, 'h74BB, 'h0C9D, -'h0267, -'h0043, 'h0132, -'h00E3, 'h00A2,
      -'h004B, 'h003C, -'h0013, 'h0003, 0, -'h0002, 0, 0, 0},
    '{-'h0001, 'h0003, -'h0008, 'h0011, -'h0010, 'h000A, 'h006B, -'h016D, 'h0350, -'h0623,
      'h0BCD, -'h1780, 'h6794, 'h234C, -'h0A78, 'h0400, -'h010A, 'h0009, 'h0034, -'h0054,
      'h0041, -'h0022, 'h000A, -'h0002, 0, 0, 0, 0, 0},
    '{'h0002, -'h0008, 'h0010, -'h0023, 'h002B, 'h001A, -'h00EB, 'h027B, -'h0548, 'h0AFA,
      -'h16FA, 'h53E0, 'h3C07, -'h1249, 'h080E, -'h0347, 'h015B, -'h0044, -'h0017, 'h0046,
      -'h0023, 'h0011, -'h0005, 0, 0, 0, 0, 0, 0},
    '{-'h0005, 'h0011, -'h0023, 'h0046, -'h0017, -'h0044, 'h015B, -'h0347, 'h080E, -'h1249,
      'h3C07, 'h53E0, -'h16FA, 'h0AFA, -'h0548, 'h027B, -'h00EB, 'h001A, 'h002B, -'h0023,
      'h0010, -'h0008, 'h0002, 0, 0, 0, 0, 0, 0}
  };

  // The first six frames after reset see an all-zero history, so that run is zero.
  // Later rows cover the saturation extremes, mono with garbage on the right,
  // and half rate with the run landing on the first of the two writes.
  drill_row_t drill [DRILL_ROWS] = '{
    '{1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{1'b1, 1'b0, 1'b0, 16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'hFFFF, 16'h1234, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h0001, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h7FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{1'b1, 1'b1, 1'b1, 16'h1234, 16'hFEDC, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
    '{1'b0, 1'b0, 1'b0, 16'h4000, 16'hC000, 1'b0, 16'h0000, 16'h0000}
  };

  xa_zigzag_resampler_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .last_of_run_o  (last_of_run_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_out.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
  end

  // One channel of one phase: each tap product is floored by the arithmetic shift.
  function automatic logic signed [15:0] zigzag_tap_sum(input int phase, input logic right_ch);
    int          acc;
    int          s;
    logic [4:0]  idx;
    logic [31:0] e;
    acc = 0;
    for (int i = 1; i <= FILTER_TAPS; i++) begin
      idx = hist_wp - 5'(i);
      e = hist_mem[idx];
      s = right_ch ? int'($signed(e[31:16])) : int'($signed(e[15:0]));
      acc += (s * zigzag[phase][i - 1]) >>> 15;
    end
    if (acc > 32767) begin
      acc = 32767;
    end else if (acc < -32768) begin
      acc = -32768;
    end
    return acc[15:0];
  endfunction

  task automatic store_frame(input logic [31:0] frame_word, inout int made);
    audio_out_t o;
    hist_mem[hist_wp] = frame_word;
    hist_wp = hist_wp + 5'd1;
    if (writes_left > 3'd1) begin
      writes_left = writes_left - 3'd1;
    end else begin
      writes_left = 3'(RUN_FRAMES);
      for (int p = 0; p < FILTER_PHASES; p++) begin
        o.left  = zigzag_tap_sum(p, 1'b0);
        o.right = zigzag_tap_sum(p, 1'b1);
        o.last  = (p == FILTER_PHASES - 1);
        pending_out = {pending_out, o};
      end
      made += FILTER_PHASES;
      runs_predicted++;
    end
  endtask

  task automatic resample_frame(input logic [15:0] l, input logic [15:0] r, output int made);
    logic [31:0] w;
    made = 0;
    w = {stereo_m ? r : l, l};
    store_frame(w, made);
    // At half rate the same frame goes into the history a second time.
    if (half_rate_m) begin
      store_frame(w, made);
    end
  endtask

  // Starts and ends on a falling edge; valid stays high into the next call when there is no gap.
  task automatic send_frame(input logic [15:0] l, input logic [15:0] r, input logic typed,
                            input logic [15:0] tl, input logic [15:0] tr);
    int made;
    while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    resample_frame(l, r, made);
    frames_sent++;
    if (typed) begin
      for (int k = pending_out.size() - made; k < pending_out.size(); k++) begin
        pending_out[k].left  = tl;
        pending_out[k].right = tr;
      end
    end
    @(negedge clk_i);
  endtask

  // Lets every expected result drain, then gives a frame without a run time to finish.
  task automatic hold_input();
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    if (sel == xzr_pkg::REG_HALF_RATE) begin
      half_rate_m = value[0];
    end else begin
      stereo_m = value[0];
    end
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Upper data bits are random; only bit 0 should matter.
  task automatic set_mode(input logic half, input logic ster);
    logic [31:0] v;
    v = $urandom;
    v[0] = half;
    write_reg(xzr_pkg::REG_HALF_RATE, v);
    v = $urandom;
    v[0] = ster;
    write_reg(xzr_pkg::REG_STEREO, v);
  endtask

  function automatic logic [15:0] draw_sample(input int k);
    case ($urandom_range(0, 9))
      0: begin
        return 16'h7FFF;
      end
      1: begin
        return 16'h8000;
      end
      2: begin
        return 16'($urandom_range(0, 64) - 32);
      end
      3: begin
        return k[0] ? 16'h7FFF : 16'h8000;
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    audio_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected result left %0d right %0d last %0b", $time,
                 left_out_o, right_out_o, last_of_run_o);
      end else begin
        want = pending_out.pop_front();
        if (left_out_o !== want.left) begin
          errors++;
          $display("%0t: left_out expected %0d got %0d", $time, want.left, left_out_o);
        end
        if (right_out_o !== want.right) begin
          errors++;
          $display("%0t: right_out expected %0d got %0d", $time, want.right, right_out_o);
        end
        if (last_of_run_o !== want.last) begin
          errors++;
          $display("%0t: last_of_run expected %0b got %0b", $time, want.last, last_of_run_o);
        end
      end
    end
  end

  initial begin
    int          seg;
    int          seg_len;
    int          done_rand;
    logic [15:0] l;
    logic [15:0] r;
    for (int i = 0; i < 32; i++) begin
      hist_mem[i] = '0;
    end
    hist_wp     = '0;
    writes_left = 3'(RUN_FRAMES);
    half_rate_m = 1'b0;
    stereo_m    = 1'b1;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int n = 0; n < DRILL_ROWS; n++) begin
      if (drill[n].cfg) begin
        hold_input();
        set_mode(drill[n].half, drill[n].ster);
      end
      send_frame(drill[n].left, drill[n].right, drill[n].typed,
                 drill[n].left_exp, drill[n].right_exp);
    end

    // Random frames in segments; the first four segments walk every mode combination.
    seg = 0;
    done_rand = 0;
    while (done_rand < RANDOM_FRAMES) begin
      hold_input();
      if (seg < 4) begin
        set_mode(seg[0], seg[1]);
      end else begin
        set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      seg_len = $urandom_range(15, 45);
      for (int k = 0; k < seg_len && done_rand < RANDOM_FRAMES; k++) begin
        steady = (done_rand >= 120) && (done_rand < 180);
        if ($urandom_range(0, 19) == 0) begin
          hold_input();
        end
        l = draw_sample(k);
        r = draw_sample(k + 1);
        send_frame(l, r, 1'b0, 16'h0000, 16'h0000);
        done_rand++;
      end
      seg++;
    end
    steady = 1'b0;

    hold_input();
    repeat (64) @(posedge clk_i);
    if (pending_out.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_out.size());
    end

    $display("Sent %0d frames, checked %0d results from %0d predicted runs, %0d register writes.",
             frames_sent, results_seen, runs_predicted, reg_writes);
    $display("Modes: full and half rate, stereo and mono; saturation extremes and stall-free run.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
